[sv/hex_text_to_bytes_parser_defines.svh]
// Assertion macros shared by the checker file of the hex text parser.
`ifndef HEX_TEXT_TO_BYTES_PARSER_DEFINES_SVH
`define HEX_TEXT_TO_BYTES_PARSER_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define HTB_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define HTB_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/htb_pkg.sv]
`default_nettype none

package htb_pkg;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    // Reported positions saturate at this value.
    localparam logic [15:0] OUT_POS_MAX = 16'hFFFF;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INVALID    = 2'd1,
        ST_END_IN_PAIR = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    // One classified input item, as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_space;
        logic       is_newline;
    } class_t;

    // Handshake between the classified-item queue and the decoder.
    typedef struct packed {
        logic   valid;
        class_t item;
    } class_if_t;

    // One result item.
    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  data_byte;
        status_t     status;
        logic [15:0] err_row;
        logic [15:0] err_col;
        logic [7:0]  err_char;
        logic        stream_done;
    } result_t;

    // Sorts one character into hex digit, space, newline or anything else.
    function automatic class_t classify(input logic [7:0] ch, input logic last);
        class_t c;
        c.ch         = ch;
        c.last       = last;
        c.is_space   = (ch == CH_SPACE);
        c.is_newline = (ch == CH_NEWLINE);
        c.is_hex     = 1'b0;
        c.nibble     = 4'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            c.is_hex = 1'b1;
            c.nibble = 4'(ch - CH_ZERO);
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F)
        begin
            c.is_hex = 1'b1;
            c.nibble = 4'(ch - CH_LOWER_A + HEX_TEN);
        end
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F)
        begin
            c.is_hex = 1'b1;
            c.nibble = 4'(ch - CH_UPPER_A + HEX_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[sv/hex_text_to_bytes_parser.sv]
// Hex text decoder: takes one text character per cycle while not full and
// turns pairs of hex digits (either case) into bytes, giving exactly one
// result item for every character. A front stage classifies each character
// into a two-entry queue; the back stage runs the pair decoder and the row
// and column counters for each item and writes a two-entry result queue.
// With pop held high it sustains one item per cycle; a result passes through
// the input queue and the result queue, both registered, to the outputs. After
// an error result every further item gives an all-zero result until reset;
// bytes delivered before the error are to be discarded by the consumer.
`default_nettype none

module hex_text_to_bytes_parser #(
    parameter int POS_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  ch,
    input  wire logic        last,
    input  wire logic        push,
    output logic             full,
    output logic             byte_valid,
    output logic [7:0]       data_byte,
    output logic [1:0]       status,
    output logic [15:0]      err_row,
    output logic [15:0]      err_col,
    output logic [7:0]       err_char,
    output logic             stream_done,
    output logic             empty,
    input  wire logic        pop
);
    import htb_pkg::*;

    class_if_t cq;
    logic      cq_take;
    result_t   res;

    // Character classification and input queue.
    htb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ch      (ch),
        .last    (last),
        .push    (push),
        .full    (full),
        .cq_out  (cq),
        .cq_take (cq_take)
    );

    // Pair decoder, position tracking and result queue.
    htb_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cq_in   (cq),
        .cq_take (cq_take),
        .res     (res),
        .empty   (empty),
        .pop     (pop)
    );

    assign byte_valid  = res.byte_valid;
    assign data_byte   = res.data_byte;
    assign status      = res.status;
    assign err_row     = res.err_row;
    assign err_col     = res.err_col;
    assign err_char    = res.err_char;
    assign stream_done = res.stream_done;

endmodule

`default_nettype wire

[sv/htb_front.sv]
`default_nettype none

module htb_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        ch,
    input  wire logic              last,
    input  wire logic              push,
    output logic                   full,
    output htb_pkg::class_if_t     cq_out,
    input  wire logic              cq_take
);
    import htb_pkg::*;

    // Two-entry queue of classified items.
    class_t     q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = cq_take && (count_reg != 2'd0);

    // The oldest classified item is offered to the decoder.
    assign cq_out.valid = (count_reg != 2'd0);
    assign cq_out.item  = q_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Each accepted character is classified on the way into the queue.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= classify(ch, last);
        end
    end

endmodule

`default_nettype wire

[sv/htb_back.sv]
`default_nettype none

module htb_back #(
    parameter int POS_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire htb_pkg::class_if_t cq_in,
    output logic                    cq_take,
    output htb_pkg::result_t        res,
    output logic                    empty,
    input  wire logic               pop
);
    import htb_pkg::*;

    localparam int EXT_W = (POS_BITS > 16) ? POS_BITS : 16;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    typedef enum logic [2:0] {
        S_PAIR_START  = 3'b001,
        S_PAIR_SECOND = 3'b010,
        S_FAILED      = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [3:0]          high_nibble_reg;
    logic [3:0]          high_nibble_next;
    logic [7:0]          first_char_reg;
    logic [7:0]          first_char_next;
    logic [POS_BITS-1:0] row_reg;
    logic [POS_BITS-1:0] row_next;
    logic [POS_BITS-1:0] col_reg;
    logic [POS_BITS-1:0] col_next;
    logic [POS_BITS-1:0] row_inc;
    logic [POS_BITS-1:0] col_inc;
    result_t             res_new;
    class_t              it;

    result_t    oq_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    // One-based position, clipped to what the result ports can carry.
    function automatic logic [15:0] report(input logic [POS_BITS-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(sat_inc(v));
        if (w > EXT_W'(OUT_POS_MAX))
        begin
            w = EXT_W'(OUT_POS_MAX);
        end
        return w[15:0];
    endfunction

    // An item is decoded whenever the result queue has a free entry.
    assign cq_take = cq_in.valid && (count_reg != 2'd2);
    assign it      = cq_in.item;
    assign row_inc = sat_inc(row_reg);
    assign col_inc = sat_inc(col_reg);

    // Decoder step for one character.
    always_comb
    begin
        state_next       = state_reg;
        high_nibble_next = high_nibble_reg;
        first_char_next  = first_char_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        res_new          = '0;
        case (state_reg)
            S_PAIR_START:
            begin
                if (it.is_space)
                begin
                    col_next            = col_inc;
                    res_new.stream_done = it.last;
                end
                else if (it.is_newline)
                begin
                    row_next            = row_inc;
                    col_next            = '0;
                    res_new.stream_done = it.last;
                end
                else if (!it.is_hex)
                begin
                    res_new.status   = ST_INVALID;
                    res_new.err_row  = report(row_reg);
                    res_new.err_col  = report(col_reg);
                    res_new.err_char = it.ch;
                    state_next       = S_FAILED;
                end
                else if (it.last)
                begin
                    // The stream ends right after a first digit.
                    col_next        = col_inc;
                    res_new.status  = ST_END_IN_PAIR;
                    res_new.err_row = report(row_reg);
                    res_new.err_col = report(col_inc);
                    state_next      = S_FAILED;
                end
                else
                begin
                    col_next         = col_inc;
                    high_nibble_next = it.nibble;
                    first_char_next  = it.ch;
                    state_next       = S_PAIR_SECOND;
                end
            end
            S_PAIR_SECOND:
            begin
                if (!it.is_hex)
                begin
                    res_new.status   = ST_INCOMPLETE;
                    res_new.err_row  = report(row_reg);
                    res_new.err_col  = report(col_reg);
                    res_new.err_char = first_char_reg;
                    state_next       = S_FAILED;
                end
                else
                begin
                    res_new.byte_valid  = 1'b1;
                    res_new.data_byte   = {high_nibble_reg, it.nibble};
                    res_new.stream_done = it.last;
                    col_next            = col_inc;
                    state_next          = S_PAIR_START;
                end
            end
            S_FAILED:
            begin
                state_next = S_FAILED;
            end
            default:
            begin
                state_next = S_FAILED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_PAIR_START;
            high_nibble_reg <= 4'd0;
            first_char_reg  <= 8'd0;
            row_reg         <= '0;
            col_reg         <= '0;
        end
        else if (cq_take)
        begin
            state_reg       <= state_next;
            high_nibble_reg <= high_nibble_next;
            first_char_reg  <= first_char_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
        end
    end

    // Two-entry result queue toward the consumer.
    assign empty  = (count_reg == 2'd0);
    assign do_pop = pop && !empty;
    assign res    = oq_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cq_take)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, cq_take} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cq_take)
        begin
            oq_reg[wr_ptr_reg] <= res_new;
        end
    end

endmodule

`default_nettype wire

[sv/htb_checker.sv]
`default_nettype none
`include "hex_text_to_bytes_parser_defines.svh"

module htb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        full,
    input wire logic        byte_valid,
    input wire logic [7:0]  data_byte,
    input wire logic [1:0]  status,
    input wire logic [15:0] err_row,
    input wire logic [15:0] err_col,
    input wire logic [7:0]  err_char,
    input wire logic        stream_done,
    input wire logic        empty,
    input wire logic        pop
);
    import htb_pkg::*;

    logic seen_err_reg;
    logic ok_status;
    logic no_err_fields;
    logic zero_result;

    assign ok_status     = (status == ST_OK);
    assign no_err_fields = (err_row == 16'd0) && (err_col == 16'd0) && (err_char == 8'd0);
    assign zero_result   = ok_status && !byte_valid && (data_byte == 8'd0) && !stream_done
                           && no_err_fields;

    // Remembers that an error item has been taken by the consumer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_err_reg <= 1'b0;
        end
        else if (pop && !empty && !ok_status)
        begin
            seen_err_reg <= 1'b1;
        end
    end

    // Both queues are empty on the edge after one seen in reset.
    `HTB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (empty && !full), "queues not empty in reset")

    // An error item carries neither a byte nor a stream end.
    `HTB_ASSERT(a_err_no_byte, (!empty && !ok_status) |-> (!byte_valid && !stream_done), "error item with byte or done")

    // A decoded byte never comes with error fields.
    `HTB_ASSERT(a_byte_clean, (!empty && byte_valid) |-> (ok_status && no_err_fields), "byte item with error fields")

    // Once an error has been delivered, every later item is all zero.
    `HTB_ASSERT(a_after_err_zero, (seen_err_reg && !empty) |-> zero_result, "item after error not zero")

    // A waiting item stays in place until it is taken.
    `HTB_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(status)), "waiting item changed")

endmodule

bind hex_text_to_bytes_parser htb_checker u_htb_checker (.*);

`default_nettype wire
